// ===== hw/rtl/pkcs7pu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_pkg: shared types and constants of the PKCS#7 pad/unpad core
// Holds the command item passed from the front end to the back end, the
// back-end state encoding and the status codes of the result channel.
// ----------------------------------------------------------------------------
package pkcs7pu_pkg;

   localparam int BLOCK_BYTES_DEFAULT = 16;

   // Widest ring index and pad count over the supported block sizes (2..128).
   localparam int IDX_MAX_W   = 7;
   localparam int COUNT_MAX_W = 8;

   // Command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] STATUS_BAD_VALUE   = 2'd2;
   localparam logic [1:0] STATUS_BAD_CONTENT = 2'd3;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_PAD_LAST,
      CMD_PUSH,
      CMD_UNPAD_LAST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic                   evict;
      logic                   bad_len;
      logic [7:0]             data;
      logic [IDX_MAX_W-1:0]   addr;
      logic [IDX_MAX_W-1:0]   base;
      logic [COUNT_MAX_W-1:0] count;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_EVICT,
      ST_VERDICT,
      ST_CMP,
      ST_RESULT,
      ST_OUT
   } back_state_type;

endpackage

// ===== hw/rtl/pkcs7pu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_req_if: input byte channel
// Valid/ready channel carrying one message byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface pkcs7pu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/pkcs7pu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_rsp_if: result channel
// Valid/ready channel carrying one output byte or a status-only result.
// ----------------------------------------------------------------------------
interface pkcs7pu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                   input status, output ready);
endinterface

// ===== hw/rtl/pkcs7_pad_unpad_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7_pad_unpad_core: PKCS#7 pad / unpad stream core
// Adds or checks and strips block padding on a byte stream, mode set by CSR.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on req_ch with a last-byte flag; results leave on rsp_ch, each
// either a data byte or, at the end of an unpad message, a status-only item.
// The one-bit mode register is written through csr_wr_en / csr_wr_data; the
// user must write it only while the core is idle (the core does not enforce
// this), and every write also drops any partial message. A passed byte goes
// through the command queue and the output register to rsp_ch. Throughput,
// while the receiver is ready: pad mode takes one item per cycle and follows
// the final byte with its 1 to BLOCK_BYTES pad bytes at one per cycle. Unpad
// mode takes one item per cycle until the tail ring is full; then the back
// end fetches each evicted byte through the registered RAM read port and
// emits it before it takes the next item. At the end of an unpad message the
// pad check reads a ring entry per cycle; the kept bytes follow one per cycle.
// Reset clears all control state and selects pad mode; ring contents stay
// undefined, which is harmless since only bytes of the current message are
// ever read. When the receiver stalls, the output register holds its item,
// the command queue absorbs up to two items, and then req_ch.ready drops.
// ----------------------------------------------------------------------------
module pkcs7_pad_unpad_core
   import pkcs7pu_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   pkcs7pu_req_if.sink   req_ch,
   pkcs7pu_rsp_if.source rsp_ch,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

   // Commands from the classifier into the queue.
   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;

   // Commands from the queue into the executor.
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   // The front end tracks length and ring occupancy and owns the mode bit.
   pkcs7pu_front #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   // The queue lets input keep flowing while the back end emits a burst.
   pkcs7pu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // The back end holds the tail ring and drives the output register.
   pkcs7pu_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (back_valid),
      .q_ready (back_ready),
      .q_cmd   (back_cmd),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== hw/rtl/pkcs7pu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_ram: generic simple dual-port RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module pkcs7pu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pkcs7pu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_front: input classifier
// Accepts bytes, tracks the message length and ring occupancy, and turns
// each byte into a command for the back end.
// ----------------------------------------------------------------------------
module pkcs7pu_front
   import pkcs7pu_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pkcs7pu_req_if.sink        req_ch,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);

   localparam int IW = $clog2(BLOCK_BYTES);
   localparam int FW = $clog2(BLOCK_BYTES + 1);

   logic          mode_ff, mode_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic          accept;
   logic [IW-1:0] len_inc;
   logic [IW-1:0] ptr_inc;
   logic          full;
   logic [FW-1:0] fill_next;
   logic [IW:0]   wr_sum;
   logic [IW-1:0] wr_addr;

   assign accept        = req_ch.valid && cmd_ready;
   assign req_ch.ready  = cmd_ready;
   assign cmd_valid     = req_ch.valid;

   assign len_inc   = (len_ff == IW'(BLOCK_BYTES - 1)) ? '0 : len_ff + 1'b1;
   assign ptr_inc   = (ptr_ff == IW'(BLOCK_BYTES - 1)) ? '0 : ptr_ff + 1'b1;
   assign full      = (fill_ff == FW'(BLOCK_BYTES));
   assign fill_next = full ? fill_ff : fill_ff + 1'b1;
   assign wr_sum    = (IW + 1)'(ptr_ff) + (IW + 1)'(fill_ff);
   assign wr_addr   = (wr_sum >= (IW + 1)'(BLOCK_BYTES))
                      ? IW'(wr_sum - (IW + 1)'(BLOCK_BYTES)) : wr_sum[IW-1:0];

   always_comb begin
      cmd         = '0;
      cmd.data    = req_ch.data_byte;
      mode_in     = mode_ff;
      len_in      = len_ff;
      ptr_in      = ptr_ff;
      fill_in     = fill_ff;

      if (mode_ff == 1'b0) begin
         cmd.kind  = req_ch.last_byte ? CMD_PAD_LAST : CMD_PASS;
         cmd.count = COUNT_MAX_W'(FW'(BLOCK_BYTES) - FW'(len_inc));
      end else begin
         cmd.kind    = req_ch.last_byte ? CMD_UNPAD_LAST : CMD_PUSH;
         cmd.evict   = full;
         cmd.addr    = IDX_MAX_W'(full ? ptr_ff : wr_addr);
         cmd.base    = IDX_MAX_W'(full ? ptr_inc : ptr_ff);
         cmd.bad_len = (len_inc != '0) || (fill_next != FW'(BLOCK_BYTES));
      end

      if (accept) begin
         len_in = len_inc;
         if (mode_ff == 1'b1) begin
            fill_in = fill_next;
            if (full) begin
               ptr_in = ptr_inc;
            end
         end
         if (req_ch.last_byte) begin
            len_in  = '0;
            ptr_in  = '0;
            fill_in = '0;
         end
      end

      // A mode write drops any partial message.
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         len_in  = '0;
         ptr_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         len_ff  <= '0;
         ptr_ff  <= '0;
         fill_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/pkcs7pu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_queue: command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pkcs7pu_queue
   import pkcs7pu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== hw/rtl/pkcs7pu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7pu_back: command executor
// Runs the commands: passes bytes, emits pad bursts, keeps the tail ring in
// a RAM, checks the padding and releases the unpadded tail.
// ----------------------------------------------------------------------------
module pkcs7pu_back
   import pkcs7pu_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_ready,
   input  cmd_type       q_cmd,
   pkcs7pu_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(BLOCK_BYTES);
   localparam int CW = $clog2(BLOCK_BYTES + 1);

   back_state_type state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  keep_ff, keep_in;
   logic [IW-1:0]  base_ff, base_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [7:0]     data_ff, data_in;
   logic           bad_len_ff, bad_len_in;
   logic           last_ff, last_in;
   logic           mismatch_ff, mismatch_in;

   logic           out_valid_ff;
   logic [7:0]     out_byte_ff;
   logic           byte_valid_ff;
   logic           out_last_ff;
   logic [1:0]     status_ff;

   logic           out_free;
   logic           emit;
   logic [7:0]     emit_byte;
   logic           emit_bv;
   logic           emit_last;
   logic [1:0]     emit_status;

   logic           ram_we;
   logic           ram_re;
   logic           rd_sel_cmd;
   logic [IW-1:0]  rd_idx;
   logic [IW:0]    ring_sum;
   logic [IW-1:0]  ring_addr;
   logic [IW-1:0]  ram_rd_addr;
   logic [7:0]     ram_rd_data;
   logic [8:0]     keep_wide;
   logic           pad_bad;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign ring_sum  = (IW + 1)'(base_ff) + (IW + 1)'(rd_idx);
   assign ring_addr = (ring_sum >= (IW + 1)'(BLOCK_BYTES))
                      ? IW'(ring_sum - (IW + 1)'(BLOCK_BYTES)) : ring_sum[IW-1:0];
   assign ram_rd_addr = rd_sel_cmd ? q_cmd.addr[IW-1:0] : ring_addr;
   assign keep_wide = 9'(BLOCK_BYTES) - {1'b0, data_ff};
   assign pad_bad   = (data_ff == 8'd0) || ({1'b0, data_ff} > 9'(BLOCK_BYTES));

   pkcs7pu_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_cmd.addr[IW-1:0]),
      .wr_data (q_cmd.data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      keep_in     = keep_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      data_in     = data_ff;
      bad_len_in  = bad_len_ff;
      last_in     = last_ff;
      mismatch_in = mismatch_ff;
      q_ready     = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      rd_sel_cmd  = 1'b0;
      rd_idx      = idx_ff;
      emit        = 1'b0;
      emit_byte   = 8'd0;
      emit_bv     = 1'b0;
      emit_last   = 1'b0;
      emit_status = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  CMD_PASS: begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_byte = q_cmd.data;
                        emit_bv   = 1'b1;
                        q_ready   = 1'b1;
                     end
                  end
                  CMD_PAD_LAST: begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_byte = q_cmd.data;
                        emit_bv   = 1'b1;
                        q_ready   = 1'b1;
                        data_in   = q_cmd.count[7:0];
                        cnt_in    = CW'(q_cmd.count);
                        state_in  = ST_PAD;
                     end
                  end
                  CMD_PUSH, CMD_UNPAD_LAST: begin
                     q_ready    = 1'b1;
                     ram_we     = 1'b1;
                     base_in    = q_cmd.base[IW-1:0];
                     bad_len_in = q_cmd.bad_len;
                     data_in    = q_cmd.data;
                     last_in    = (q_cmd.kind == CMD_UNPAD_LAST);
                     if (q_cmd.evict) begin
                        // Fetch the oldest byte in the same cycle it is overwritten.
                        ram_re     = 1'b1;
                        rd_sel_cmd = 1'b1;
                        state_in   = ST_EVICT;
                     end else if (q_cmd.kind == CMD_UNPAD_LAST) begin
                        state_in = ST_VERDICT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = data_ff;
               emit_bv   = 1'b1;
               emit_last = (cnt_ff == CW'(1));
               cnt_in    = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = ram_rd_data;
               emit_bv   = 1'b1;
               state_in  = last_ff ? ST_VERDICT : ST_IDLE;
            end
         end
         ST_VERDICT: begin
            if (bad_len_ff) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = STATUS_BAD_LENGTH;
                  state_in    = ST_IDLE;
               end
            end else if (pad_bad) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = STATUS_BAD_VALUE;
                  state_in    = ST_IDLE;
               end
            end else begin
               keep_in     = keep_wide[IW-1:0];
               idx_in      = keep_wide[IW-1:0];
               rd_idx      = keep_wide[IW-1:0];
               ram_re      = 1'b1;
               mismatch_in = 1'b0;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            // One pad byte compared per cycle while the next one is read.
            if (ram_rd_data != data_ff) begin
               mismatch_in = 1'b1;
            end
            if (idx_ff == IW'(BLOCK_BYTES - 1)) begin
               state_in = ST_RESULT;
            end else begin
               rd_idx = idx_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               ram_re = 1'b1;
            end
         end
         ST_RESULT: begin
            if (mismatch_ff) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_last   = 1'b1;
                  emit_status = STATUS_BAD_CONTENT;
                  state_in    = ST_IDLE;
               end
            end else if (keep_ff == '0) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               rd_idx   = '0;
               idx_in   = '0;
               ram_re   = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = ram_rd_data;
               emit_bv   = 1'b1;
               emit_last = (idx_ff == keep_ff - 1'b1);
               if (idx_ff == keep_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx = idx_ff + 1'b1;
                  idx_in = idx_ff + 1'b1;
                  ram_re = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      keep_ff     <= keep_in;
      base_ff     <= base_in;
      cnt_ff      <= cnt_in;
      data_ff     <= data_in;
      bad_len_ff  <= bad_len_in;
      last_ff     <= last_in;
      mismatch_ff <= mismatch_in;
      if (emit) begin
         out_byte_ff   <= emit_byte;
         byte_valid_ff <= emit_bv;
         out_last_ff   <= emit_last;
         status_ff     <= emit_status;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.byte_valid = byte_valid_ff;
   assign rsp_ch.out_last   = out_last_ff;
   assign rsp_ch.status     = status_ff;

endmodule

// ===== verif/pkcs7_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7_result_checker: result predictor and scoreboard for the pad/unpad core
// Watches the byte, result and mode-register ports, works out the result
// items that each accepted byte must cause and compares them in order with
// the items that the core hands out.
// ----------------------------------------------------------------------------
module pkcs7_result_checker
   import pkcs7pu_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   pkcs7pu_req_if req_mon,
   pkcs7pu_rsp_if rsp_mon,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data,
   output int     failure_count,
   output int     results_pending
);

   localparam int BLOCK        = BLOCK_BYTES_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       out_last;
      logic [1:0] status;
   } rsp_item_type;

   rsp_item_type awaited_results[$];
   logic [7:0]   tail_bytes[BLOCK];
   int           oldest_slot;
   int           bytes_held;
   int           length_mod;
   logic         unpad_mode;
   int           mismatches;

   function automatic void queue_result(logic [7:0] b, logic v, logic l, logic [1:0] s);
      rsp_item_type item;
      item.out_byte   = b;
      item.byte_valid = v;
      item.out_last   = l;
      item.status     = s;
      awaited_results.push_back(item);
   endfunction

   function automatic void clear_message();
      oldest_slot = 0;
      bytes_held  = 0;
      length_mod  = 0;
   endfunction

   function automatic void predict_from_byte(logic [7:0] b, logic l);
      int   pad_count;
      int   keep;
      logic pad_ok;
      length_mod = (length_mod + 1) % BLOCK;
      if (!unpad_mode) begin
         queue_result(b, 1'b1, 1'b0, STATUS_OK);
         if (l) begin
            pad_count = BLOCK - length_mod;
            for (int i = 0; i < pad_count; i++)
               queue_result(8'(pad_count), 1'b1, i == pad_count - 1, STATUS_OK);
            clear_message();
         end
         return;
      end
      // Unpad: a full ring gives up its oldest byte to make room.
      if (bytes_held >= BLOCK) begin
         queue_result(tail_bytes[oldest_slot], 1'b1, 1'b0, STATUS_OK);
         tail_bytes[oldest_slot] = b;
         oldest_slot = (oldest_slot + 1) % BLOCK;
      end else begin
         tail_bytes[(oldest_slot + bytes_held) % BLOCK] = b;
         bytes_held++;
      end
      if (!l)
         return;
      pad_count = int'(b);
      if (length_mod != 0 || bytes_held < BLOCK) begin
         queue_result(8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH);
      end else if (pad_count == 0 || pad_count > BLOCK) begin
         queue_result(8'h00, 1'b0, 1'b1, STATUS_BAD_VALUE);
      end else begin
         keep   = BLOCK - pad_count;
         pad_ok = 1'b1;
         for (int i = keep; i < BLOCK; i++)
            if (tail_bytes[(oldest_slot + i) % BLOCK] != b)
               pad_ok = 1'b0;
         if (!pad_ok) begin
            queue_result(8'h00, 1'b0, 1'b1, STATUS_BAD_CONTENT);
         end else if (keep == 0) begin
            queue_result(8'h00, 1'b0, 1'b1, STATUS_OK);
         end else begin
            for (int i = 0; i < keep; i++)
               queue_result(tail_bytes[(oldest_slot + i) % BLOCK], 1'b1, i == keep - 1,
                            STATUS_OK);
         end
      end
      clear_message();
   endfunction

   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         awaited_results.delete();
         clear_message();
         unpad_mode = 1'b0;
         mismatches = 0;
      end else begin
         if (csr_wr_en) begin
            unpad_mode = csr_wr_data;
            clear_message();
         end
         if (req_mon.valid && req_mon.ready)
            predict_from_byte(req_mon.data_byte, req_mon.last_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.out_byte   = rsp_mon.out_byte;
            seen.byte_valid = rsp_mon.byte_valid;
            seen.out_last   = rsp_mon.out_last;
            seen.status     = rsp_mon.status;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result: byte %02h valid %b last %b status %0d",
                           $realtime, seen.out_byte, seen.byte_valid, seen.out_last,
                           seen.status);
            end else begin
               want = awaited_results.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected byte %02h valid %b last %b status %0d",
                              $realtime, want.out_byte, want.byte_valid, want.out_last,
                              want.status,
                              ", got byte %02h valid %b last %b status %0d",
                              seen.out_byte, seen.byte_valid, seen.out_last,
                              seen.status);
               end
            end
         end
      end
      results_pending <= awaited_results.size();
      failure_count   <= mismatches;
   end

endmodule

// ===== verif/pkcs7_pad_unpad_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs7_pad_unpad_core_tb: testbench top of the PKCS#7 pad/unpad core
// Feeds directed and random messages in both modes under changing sender and
// receiver idling, lets the result checker score every item and prints the
// verdict.
// ----------------------------------------------------------------------------
module pkcs7_pad_unpad_core_tb;
   import pkcs7pu_pkg::*;

   localparam int BLOCK       = BLOCK_BYTES_DEFAULT;
   // Cycles to let the core finish internal work (ring writes, pad check)
   // after the last expected item, before a mode write or the verdict.
   localparam int SETTLE      = 40;
   // Length of the long receiver hold-off that fills the core and its queue.
   localparam int LONG_HOLD   = 80;
   localparam int PAD_ITEMS   = 60;
   localparam int UNPAD_ITEMS = 65;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   pkcs7pu_req_if req_ch ();
   pkcs7pu_rsp_if rsp_ch ();

   int   failure_count;
   int   results_pending;
   int   items_sent;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   hold_left;
   logic hold_start;

   always #6 clock = ~clock;

   pkcs7_pad_unpad_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pkcs7_result_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failure_count   (failure_count),
      .results_pending (results_pending)
   );

   // Receiver. It stalls at random at the current rate, and when asked it
   // holds ready low for a long stretch so that the output register and the
   // command queue fill up and the core has to drop req_ch.ready.
   always @(posedge clock) begin
      if (hold_start)
         hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Offers one byte, after a random number of idle cycles, and returns on
   // the clock edge at which the core takes it.
   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= l;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Stops offering bytes and waits until every expected item has arrived,
   // then lets the core settle. Called right after a handshake edge.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the mode register; the core must be idle when this is called.
   task automatic write_mode(input logic unpad);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= unpad;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Builds one random message and sends it. In pad mode any content will do.
   // In unpad mode most messages are properly padded so that the pad checks
   // and the tail release are reached; the rest have a bad length, a bad pad
   // value, a corrupted pad byte, or are plain noise.
   task automatic send_random_message(input logic unpad);
      logic [7:0] msg[$];
      int         len;
      int         pad_count;
      int         kind;
      int         spot;
      if (!unpad) begin
         case ($urandom_range(0, 7))
            0:       len = BLOCK * $urandom_range(1, 2);
            1:       len = $urandom_range(BLOCK + 1, 40);
            default: len = $urandom_range(1, BLOCK - 1);
         endcase
         for (int i = 0; i < len; i++)
            msg.push_back(8'($urandom_range(0, 255)));
      end else begin
         kind = $urandom_range(0, 9);
         // A message longer than one block also evicts on its final byte.
         len  = ($urandom_range(0, 3) == 0) ? BLOCK * $urandom_range(2, 3) : BLOCK;
         case ($urandom_range(0, 5))
            0:       pad_count = BLOCK;
            1:       pad_count = 1;
            default: pad_count = $urandom_range(1, BLOCK);
         endcase
         if (kind == 8 && pad_count < 2)
            pad_count = 2;
         if (kind == 6 || kind == 9)
            len = $urandom_range(1, 40);
         if (kind == 6 && len % BLOCK == 0)
            len++;
         for (int i = 0; i < len; i++)
            msg.push_back(8'($urandom_range(0, 255)));
         if (kind <= 5 || kind == 8)
            for (int i = len - pad_count; i < len; i++)
               msg[i] = 8'(pad_count);
         if (kind == 7)
            msg[len - 1] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(BLOCK + 1, 255));
         if (kind == 8) begin
            // Corrupt one pad byte other than the final one.
            spot      = $urandom_range(len - pad_count, len - 2);
            msg[spot] = msg[spot] ^ 8'($urandom_range(1, 255));
         end
      end
      foreach (msg[i])
         send_byte(msg[i], i == msg.size() - 1);
   endtask

   initial begin
      int phase_start;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      hold_start       = 1'b0;
      hold_left        = 0;
      items_sent       = 0;
      tx_idle_pct      = 22;
      rx_idle_pct      = 61;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Pad mode first, written with the reset value.
      write_mode(1'b0);
      // A one-byte message takes the longest pad run of the short messages.
      send_byte(8'hFF, 1'b1);
      // A length that is a whole block gets a full block of padding.
      for (int i = 0; i < BLOCK; i++)
         send_byte(8'(i * 17), i == BLOCK - 1);
      // A partial message is dropped by the mode write that follows.
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      wait_idle();
      write_mode(1'b1);
      // Unpad with a length that is not a block multiple.
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h01, 1'b1);
      // A partial unpad message, then a write of the same mode drops it.
      send_byte(8'h10, 1'b0);
      send_byte(8'h10, 1'b0);
      wait_idle();
      write_mode(1'b1);

      // Random part in three idling phases, each with a pad and an unpad run.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 22;
               rx_idle_pct <= 61;
            end
            1: begin
               tx_idle_pct = 61;
               rx_idle_pct <= 22;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
            end
         endcase
         wait_idle();
         write_mode(1'b0);
         // Long receiver hold-off while the sender keeps offering bytes.
         hold_start <= 1'b1;
         @(posedge clock);
         hold_start <= 1'b0;
         phase_start = items_sent;
         while (items_sent - phase_start < PAD_ITEMS)
            send_random_message(1'b0);
         // The sender pauses here until every expected item has come.
         wait_idle();
         write_mode(1'b1);
         phase_start = items_sent;
         while (items_sent - phase_start < UNPAD_ITEMS)
            send_random_message(1'b1);
      end

      wait_idle();
      if (failure_count == 0 && results_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== pkcs7_pad_unpad_core.f =====
hw/rtl/pkcs7pu_pkg.sv
hw/rtl/pkcs7pu_req_if.sv
hw/rtl/pkcs7pu_rsp_if.sv
hw/rtl/pkcs7pu_ram.sv
hw/rtl/pkcs7pu_front.sv
hw/rtl/pkcs7pu_queue.sv
hw/rtl/pkcs7pu_back.sv
hw/rtl/pkcs7_pad_unpad_core.sv
verif/pkcs7_result_checker.sv
verif/pkcs7_pad_unpad_core_tb.sv
